/* hdl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros
// Clocked assertion helpers included by the top-level rtl file of the list.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, held off while reset is asserted
`define IDEL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked check that also runs during reset
`define IDEL_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hdl/idel_pkg.sv */
// ----------------------------------------------------------------------------
// idel_pkg
// Shared constants and types of the indexed double-ended list.
// ----------------------------------------------------------------------------
`default_nettype none

package idel_pkg;

  localparam int MAX_ELEMENTS = 64;
  localparam int IDX_W        = 7;
  localparam int WORD_W       = 32;

  localparam logic [IDX_W-1:0] MAX_CNT = IDX_W'(MAX_ELEMENTS);

  typedef enum logic [2:0] {
    CMD_PUSH_BACK  = 3'd0,
    CMD_PUSH_FRONT = 3'd1,
    CMD_POP_BACK   = 3'd2,
    CMD_POP_FRONT  = 3'd3,
    CMD_INSERT     = 3'd4,
    CMD_ERASE      = 3'd5,
    CMD_READ       = 3'd6,
    CMD_WRITE      = 3'd7
  } cmd_t;

  // operation broadcast to every cell of the chain
  typedef enum logic [1:0] {
    OP_NOP = 2'd0,
    OP_INS = 2'd1,
    OP_ERA = 2'd2,
    OP_WR  = 2'd3
  } cell_op_t;

  typedef struct packed {
    cell_op_t           op;
    logic [IDX_W-1:0]   pos;
    logic [WORD_W-1:0]  word;
  } cell_cmd_t;

endpackage

`default_nettype wire

/* hdl/indexed_double_ended_list.sv */
// ----------------------------------------------------------------------------
// indexed_double_ended_list
// Ordered list of signed 32-bit words held in a chain of shifting cells.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  carries one command per transaction: push back/front, pop back/front,
//         insert, erase, read or write at an index.
//   out_* returns one result per command: ok flag, read word, element count.
//   Every command completes on its accepting edge: the chain of cells shifts
//   all affected slots, and the result is loaded into the output register on
//   the same edge (one command per cycle while in_tready is high).
//   A read selects the addressed cell and combines all cells onto the read
//   bus ahead of the output register.
//   in_tready is high while the output register is empty or being taken,
//   so a stalled receiver holds one result and then stalls the input.
//   Reset clears the element count and the output valid flag; the output data
//   and slot contents are not cleared and are never visible before being written.
// ----------------------------------------------------------------------------
`default_nettype none

module indexed_double_ended_list (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [47:0] in_tdata,   // command[2:0], index[9:3], value[41:10], zero pad
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [39:0] out_tdata   // ok[0], read_value[32:1], count[39:33]
);

  localparam int N = idel_pkg::MAX_ELEMENTS;

  idel_pkg::cmd_t                  cmd;
  logic [idel_pkg::IDX_W-1:0]      idx;
  logic [idel_pkg::WORD_W-1:0]     word;
  logic                            acc;
  logic [idel_pkg::IDX_W-1:0]      count_r;
  logic [idel_pkg::IDX_W-1:0]      count_nxt;
  logic                            ok;
  idel_pkg::cell_cmd_t             ccmd;
  logic                            out_valid_r;
  logic [39:0]                     out_data_r;
  logic [idel_pkg::WORD_W-1:0]     rd_word;
  logic [idel_pkg::WORD_W-1:0]     cell_data [N];
  logic [idel_pkg::WORD_W-1:0]     cell_rd   [N];
  logic                            not_full;
  logic                            not_empty;

  assign cmd  = idel_pkg::cmd_t'(in_tdata[2:0]);
  assign idx  = in_tdata[9:3];
  assign word = in_tdata[41:10];

  assign in_tready = !out_valid_r || out_tready;
  assign acc       = in_tvalid && in_tready;

  assign not_full  = (count_r < idel_pkg::MAX_CNT);
  assign not_empty = (count_r != '0);

  // decode into one broadcast operation for the chain
  always_comb begin
    ok        = 1'b0;
    ccmd.op   = idel_pkg::OP_NOP;
    ccmd.pos  = idx;
    ccmd.word = word;
    count_nxt = count_r;
    case (cmd)
      idel_pkg::CMD_PUSH_BACK: begin
        ok       = not_full;
        ccmd.pos = count_r;
        if (ok) ccmd.op = idel_pkg::OP_INS;
      end
      idel_pkg::CMD_PUSH_FRONT: begin
        ok       = not_full;
        ccmd.pos = '0;
        if (ok) ccmd.op = idel_pkg::OP_INS;
      end
      idel_pkg::CMD_POP_BACK: begin
        ok       = not_empty;
        ccmd.pos = count_r - 1'b1;
        if (ok) ccmd.op = idel_pkg::OP_ERA;
      end
      idel_pkg::CMD_POP_FRONT: begin
        ok       = not_empty;
        ccmd.pos = '0;
        if (ok) ccmd.op = idel_pkg::OP_ERA;
      end
      idel_pkg::CMD_INSERT: begin
        ok = not_full && (idx <= count_r);
        if (ok) ccmd.op = idel_pkg::OP_INS;
      end
      idel_pkg::CMD_ERASE: begin
        ok = (idx < count_r);
        if (ok) ccmd.op = idel_pkg::OP_ERA;
      end
      idel_pkg::CMD_READ: begin
        ok = (idx < count_r);
      end
      idel_pkg::CMD_WRITE: begin
        ok = (idx < count_r);
        if (ok) ccmd.op = idel_pkg::OP_WR;
      end
      default: ok = 1'b0;
    endcase
    if (!acc) begin
      ccmd.op = idel_pkg::OP_NOP;
    end
    case (ccmd.op)
      idel_pkg::OP_INS: count_nxt = count_r + 1'b1;
      idel_pkg::OP_ERA: count_nxt = count_r - 1'b1;
      default:          count_nxt = count_r;
    endcase
  end

  for (genvar i = 0; i < N; i++) begin : g_cell
    logic [idel_pkg::WORD_W-1:0] left_w;
    logic [idel_pkg::WORD_W-1:0] right_w;
    if (i == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid_l
      assign left_w = cell_data[i-1];
    end
    if (i == N-1) begin : g_last
      assign right_w = cell_data[i];
    end else begin : g_mid_r
      assign right_w = cell_data[i+1];
    end
    idel_cell u_cell (
      .clk        (clk),
      .cmd        (ccmd),
      .slot       (idel_pkg::IDX_W'(i)),
      .left_data  (left_w),
      .right_data (right_w),
      .data_o     (cell_data[i]),
      .rd_o       (cell_rd[i])
    );
  end

  // only the addressed cell drives a nonzero word
  always_comb begin
    rd_word = '0;
    for (int i = 0; i < N; i++) begin
      rd_word = rd_word | cell_rd[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (acc) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      out_data_r <= {count_nxt,
                     (ok && (cmd == idel_pkg::CMD_READ)) ? rd_word : '0,
                     ok};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

`include "assert_macros.svh"

  `IDEL_ASSERT(a_count_bound, count_r <= idel_pkg::MAX_CNT, "element count above capacity")
  `IDEL_ASSERT(a_count_idle, !acc |=> $stable(count_r), "count changed without a command")
  `IDEL_ASSERT(a_ins_grow, (acc && ccmd.op == idel_pkg::OP_INS) |=> (count_r == $past(count_r) + 1'b1), "insert did not grow the list")
  `IDEL_ASSERT(a_rd_ok, (out_tvalid && out_tdata[32:1] != '0) |-> out_tdata[0], "read word on a rejected command")
  `IDEL_ASSERT_ALWAYS(a_rst_idle, !rst_n |=> !out_tvalid, "result pending after reset")

endmodule

`default_nettype wire

/* hdl/idel_cell.sv */
// ----------------------------------------------------------------------------
// idel_cell
// One slot of the list: shifts from its neighbors on insert and erase,
// loads on write, and drives its word onto the read bus when selected.
// ----------------------------------------------------------------------------
`default_nettype none

module idel_cell (
  input  wire logic                          clk,
  input  wire idel_pkg::cell_cmd_t           cmd,
  input  wire logic [idel_pkg::IDX_W-1:0]    slot,
  input  wire logic [idel_pkg::WORD_W-1:0]   left_data,
  input  wire logic [idel_pkg::WORD_W-1:0]   right_data,
  output logic      [idel_pkg::WORD_W-1:0]   data_o,
  output logic      [idel_pkg::WORD_W-1:0]   rd_o
);

  logic [idel_pkg::WORD_W-1:0] data_r;
  logic [idel_pkg::WORD_W-1:0] data_nxt;
  logic                        hit;
  logic                        above;

  assign hit   = (slot == cmd.pos);
  assign above = (slot > cmd.pos);

  always_comb begin
    data_nxt = data_r;
    case (cmd.op)
      idel_pkg::OP_INS: begin
        if (above) begin
          data_nxt = left_data;
        end else if (hit) begin
          data_nxt = cmd.word;
        end
      end
      idel_pkg::OP_ERA: begin
        if (above || hit) begin
          data_nxt = right_data;
        end
      end
      idel_pkg::OP_WR: begin
        if (hit) begin
          data_nxt = cmd.word;
        end
      end
      default: data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_o = data_r;
  assign rd_o   = hit ? data_r : '0;

endmodule

`default_nettype wire

/* tb/sv/indexed_double_ended_list_test.sv */
// ----------------------------------------------------------------------------
// indexed_double_ended_list_test
// Self-checking bench for the indexed double-ended list: a queue-fed stream
// driver with bursty traffic, a monitor with its own stall pattern, and a
// word-level shadow of the list that predicts ok, read word and count.
// ----------------------------------------------------------------------------
`default_nettype none

module indexed_double_ended_list_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int RANDOM_PHASES = 16;
  localparam int PHASE_ITEMS   = 100;
  localparam int LONG_HOLD_AT  = 500;
  localparam int LONG_HOLD_LEN = 250;

  typedef enum int {MIX_GROW, MIX_SHRINK, MIX_ANY} traffic_mix_t;

  typedef struct {
    idel_pkg::cmd_t                   cmd;
    logic [idel_pkg::IDX_W-1:0]       index;
    logic [idel_pkg::WORD_W-1:0]      value;
    bit                               drain_first;
  } list_cmd_t;

  typedef struct {
    logic                             ok;
    logic [idel_pkg::WORD_W-1:0]      read_value;
    logic [idel_pkg::IDX_W-1:0]       count;
  } list_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata = '0;   // command[2:0], index[9:3], value[41:10], zero pad
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;       // ok[0], read_value[32:1], count[39:33]

  indexed_double_ended_list u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  list_cmd_t    command_queue[$];
  list_result_t pending_results[$];
  int           mismatch_count = 0;

  // shadow of the list contents, updated as each command transaction lands
  logic [idel_pkg::WORD_W-1:0] list_words [0:idel_pkg::MAX_ELEMENTS-1];
  int                          list_count = 0;

  task automatic apply_list_command(input list_cmd_t c);
    list_result_t r;
    int pos;
    int k;
    r.ok = 1'b0;
    r.read_value = '0;
    case (c.cmd)
      idel_pkg::CMD_PUSH_BACK, idel_pkg::CMD_PUSH_FRONT, idel_pkg::CMD_INSERT: begin
        pos = (c.cmd == idel_pkg::CMD_PUSH_BACK) ? list_count :
              (c.cmd == idel_pkg::CMD_PUSH_FRONT) ? 0 : int'(c.index);
        if (list_count < idel_pkg::MAX_ELEMENTS && pos <= list_count) begin
          for (k = list_count; k > pos; k--) list_words[k] = list_words[k-1];
          list_words[pos] = c.value;
          list_count++;
          r.ok = 1'b1;
        end
      end
      idel_pkg::CMD_POP_BACK, idel_pkg::CMD_POP_FRONT, idel_pkg::CMD_ERASE: begin
        pos = (c.cmd == idel_pkg::CMD_POP_BACK) ? list_count - 1 :
              (c.cmd == idel_pkg::CMD_POP_FRONT) ? 0 : int'(c.index);
        if (pos >= 0 && pos < list_count) begin
          for (k = pos; k + 1 < list_count; k++) list_words[k] = list_words[k+1];
          list_count--;
          r.ok = 1'b1;
        end
      end
      idel_pkg::CMD_READ: begin
        if (int'(c.index) < list_count) begin
          r.read_value = list_words[c.index];
          r.ok = 1'b1;
        end
      end
      default: begin
        if (int'(c.index) < list_count) begin
          list_words[c.index] = c.value;
          r.ok = 1'b1;
        end
      end
    endcase
    r.count = idel_pkg::IDX_W'(list_count);
    pending_results.insert(pending_results.size(), r);
  endtask

  // ---------------------------------------------------------------- driver
  list_cmd_t offered;
  int        burst_left = 0;
  int        gap_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      burst_left = 0;
      gap_left = 0;
    end else begin
      if (in_tvalid && in_tready) apply_list_command(offered);
      if (!in_tvalid || in_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_tvalid <= 1'b0;
        end else if (command_queue.size() != 0 &&
                     !(command_queue[0].drain_first && pending_results.size() != 0)) begin
          offered = command_queue[0];
          command_queue.delete(0);
          in_tdata <= {6'b0, offered.value, offered.index, offered.cmd};
          in_tvalid <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------- monitor
  list_result_t got;
  list_result_t want;
  int           results_seen = 0;
  int           stall_phase = 0;
  int           hold_left = 0;
  bit           long_hold_done = 1'b0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got.ok = out_tdata[0];
        got.read_value = out_tdata[32:1];
        got.count = out_tdata[39:33];
        results_seen++;
        if (pending_results.size() == 0) begin
          $error("result transaction with nothing expected: ok=%0d read_value=%0d count=%0d",
                 got.ok, $signed(got.read_value), got.count);
          mismatch_count++;
        end else begin
          want = pending_results[0];
          pending_results.delete(0);
          if (got.ok !== want.ok) begin
            $error("ok: expected %0d, actual %0d", want.ok, got.ok);
            mismatch_count++;
          end
          if (got.read_value !== want.read_value) begin
            $error("read_value: expected %0d, actual %0d",
                   $signed(want.read_value), $signed(got.read_value));
            mismatch_count++;
          end
          if (got.count !== want.count) begin
            $error("count: expected %0d, actual %0d", want.count, got.count);
            mismatch_count++;
          end
        end
      end

      // one long hold-off lets the output register fill and stall the input
      if (!long_hold_done && results_seen >= LONG_HOLD_AT) begin
        long_hold_done = 1'b1;
        hold_left = LONG_HOLD_LEN;
      end
      stall_phase++;
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        case ((stall_phase / 97) % 4)
          0:       out_tready <= 1'b1;
          1:       out_tready <= stall_phase[0];
          2:       out_tready <= ($urandom_range(0, 3) != 0);
          default: out_tready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // -------------------------------------------------------------- watchdog
  int cycle_count = 0;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("indexed_double_ended_list verification failed");
      $finish;
    end
  end

  // ------------------------------------------------------------- stimulus
  int gen_count = 0;   // rough element count, only used to aim indices

  task automatic queue_command(input idel_pkg::cmd_t cmd, input int index,
                               input logic [31:0] value, input bit drain_first = 1'b0);
    list_cmd_t c;
    c.cmd = cmd;
    c.index = idel_pkg::IDX_W'(index);
    c.value = value;
    c.drain_first = drain_first;
    command_queue.insert(command_queue.size(), c);
    case (cmd)
      idel_pkg::CMD_PUSH_BACK, idel_pkg::CMD_PUSH_FRONT:
        if (gen_count < idel_pkg::MAX_ELEMENTS) gen_count++;
      idel_pkg::CMD_INSERT:
        if (gen_count < idel_pkg::MAX_ELEMENTS && index <= gen_count) gen_count++;
      idel_pkg::CMD_POP_BACK, idel_pkg::CMD_POP_FRONT: if (gen_count > 0) gen_count--;
      idel_pkg::CMD_ERASE: if (index < gen_count) gen_count--;
      default: ;
    endcase
  endtask

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 9))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return 32'h0000_0000;
      3:       return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  function automatic idel_pkg::cmd_t pick_command(input traffic_mix_t mix);
    int r;
    r = $urandom_range(0, 99);
    if (mix == MIX_GROW && r < 65) begin
      case (r % 3)
        0:       return idel_pkg::CMD_PUSH_BACK;
        1:       return idel_pkg::CMD_PUSH_FRONT;
        default: return idel_pkg::CMD_INSERT;
      endcase
    end
    if (mix == MIX_SHRINK && r < 65) begin
      case (r % 3)
        0:       return idel_pkg::CMD_POP_BACK;
        1:       return idel_pkg::CMD_POP_FRONT;
        default: return idel_pkg::CMD_ERASE;
      endcase
    end
    return idel_pkg::cmd_t'($urandom_range(0, 7));
  endfunction

  function automatic int pick_index();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return $urandom_range(0, gen_count);
    if (r < 80) return (gen_count == 0) ? 0 : gen_count - 1;
    return $urandom_range(0, 127);
  endfunction

  initial begin
    traffic_mix_t   mix;
    idel_pkg::cmd_t cmd;

    // empty list: every pop, erase, read, write and out-of-range insert is turned away
    queue_command(idel_pkg::CMD_POP_BACK,   0,   32'h1);
    queue_command(idel_pkg::CMD_POP_FRONT,  0,   32'h2);
    queue_command(idel_pkg::CMD_READ,       0,   32'h3);
    queue_command(idel_pkg::CMD_WRITE,      0,   32'h4);
    queue_command(idel_pkg::CMD_ERASE,      0,   32'h5);
    queue_command(idel_pkg::CMD_INSERT,     1,   32'h6);
    queue_command(idel_pkg::CMD_READ,       127, 32'hffff_ffff);
    // build a short list with extreme words, insert at index equal to count, then read, write, erase and pop it
    queue_command(idel_pkg::CMD_PUSH_BACK,  0,   32'h7fff_ffff);
    queue_command(idel_pkg::CMD_PUSH_FRONT, 0,   32'h8000_0000);
    queue_command(idel_pkg::CMD_INSERT,     2,   32'h0000_0000);
    queue_command(idel_pkg::CMD_INSERT,     1,   32'hffff_ffff);
    queue_command(idel_pkg::CMD_READ,       0,   32'h0);
    queue_command(idel_pkg::CMD_READ,       1,   32'h0);
    queue_command(idel_pkg::CMD_READ,       2,   32'h0);
    queue_command(idel_pkg::CMD_READ,       3,   32'h0);
    queue_command(idel_pkg::CMD_WRITE,      3,   32'h5555_5555);
    queue_command(idel_pkg::CMD_READ,       3,   32'h0);
    queue_command(idel_pkg::CMD_WRITE,      4,   32'haaaa_aaaa);
    queue_command(idel_pkg::CMD_ERASE,      1,   32'h0);
    queue_command(idel_pkg::CMD_ERASE,      64,  32'h0);
    queue_command(idel_pkg::CMD_READ,       1,   32'h0);
    queue_command(idel_pkg::CMD_POP_BACK,   0,   32'h0);
    queue_command(idel_pkg::CMD_POP_FRONT,  0,   32'h0);
    queue_command(idel_pkg::CMD_READ,       0,   32'h0);

    // random phases swing the list between empty and full
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p % 4)
        0:       mix = MIX_GROW;
        2:       mix = MIX_SHRINK;
        default: mix = MIX_ANY;
      endcase
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        cmd = pick_command(mix);
        queue_command(cmd, pick_index(), pick_word(), (i == 0) && (p % 6 == 5));
      end
    end

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    do @(negedge clk);
    while (command_queue.size() != 0 || in_tvalid || pending_results.size() != 0);
    repeat (4) @(negedge clk);

    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("indexed_double_ended_list verification clean");
    end else begin
      $display("indexed_double_ended_list verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* indexed_double_ended_list.f */
+incdir+hdl
hdl/idel_pkg.sv
hdl/idel_cell.sv
hdl/indexed_double_ended_list.sv
tb/sv/indexed_double_ended_list_test.sv
